/* design/sfm_pkg.sv */
// sfm_pkg: shared types, constants and phase encoding for the serial frame master
// depends on nothing; imported by sfm_step, serial_frame_master, sfm_checker and tb_serial_frame_master

package sfm_pkg;

    // frame geometry
    localparam int unsigned ADDR_BITS = 10;
    localparam int unsigned DATA_BITS = 8;
    localparam int unsigned START_LEN = 5;
    localparam logic [START_LEN-1:0] START_PATTERN = 5'b11001;

    // bit counter must reach the longest phase length
    localparam int unsigned MAX_LEN_AD = (ADDR_BITS > DATA_BITS) ? ADDR_BITS : DATA_BITS;
    localparam int unsigned MAX_LEN = (MAX_LEN_AD > START_LEN) ? MAX_LEN_AD : START_LEN;
    localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

    // phase codes as seen on the result port
    localparam int unsigned PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_CODE_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CODE_START = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CODE_ADDR  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_CODE_DATA  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CODE_STOP  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CODE_LOST  = 3'd5;

    // operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // internal frame phase, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_START = 6'b000010,
        ST_ADDR  = 6'b000100,
        ST_DATA  = 6'b001000,
        ST_STOP  = 6'b010000,
        ST_LOST  = 6'b100000
    } t_phase;

    // frame state carried from one transaction to the next
    typedef struct packed {
        t_phase               phase;
        logic [CNT_W-1:0]     cnt;
        logic [ADDR_BITS-1:0] addr;
        logic [DATA_BITS-1:0] data;
        logic [DATA_BITS-1:0] rx;
        logic                 arb;
    } t_state;

    // one result transaction
    typedef struct packed {
        logic                 drive_bit;
        logic                 out_bit;
        logic [PHASE_W-1:0]   phase;
        logic [DATA_BITS-1:0] rx_byte;
        logic                 rx_done;
        logic                 lost_arb;
        logic                 stop_hold;
    } t_result;

    // one-hot phase to port code
    function automatic logic [PHASE_W-1:0] phase_code(input t_phase ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            ST_START: code = PH_CODE_START;
            ST_ADDR:  code = PH_CODE_ADDR;
            ST_DATA:  code = PH_CODE_DATA;
            ST_STOP:  code = PH_CODE_STOP;
            ST_LOST:  code = PH_CODE_LOST;
            default:  code = PH_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

/* design/serial_frame_master.sv */
// serial_frame_master: top level, frame state registers and result register
// depends on sfm_pkg and sfm_step
//
// latency: the result of a transaction is valid on the cycle after it is accepted
// throughput: one transaction per cycle unless the sink stalls a waiting result; frame state updates in a single step
// the result register frees and refills in the same cycle when the output is taken
// reset (synchronous, active low): idle phase, counters, buffers and flags cleared,
// no result pending

module serial_frame_master import sfm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_operation,
    input  logic [ADDR_BITS-1:0] i_address,
    input  logic [DATA_BITS-1:0] i_tx_byte,
    input  logic                 i_rx_bit,
    input  logic                 i_arb_line,
    // output channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_drive_bit,
    output logic                 o_out_bit,
    output logic [PHASE_W-1:0]   o_phase,
    output logic [DATA_BITS-1:0] o_rx_byte,
    output logic                 o_rx_done,
    output logic                 o_lost_arb,
    output logic                 o_stop_hold
);

    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    accept;

    // hold off input only while a result is waiting and the sink stalls
    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    sfm_step u_sfm_step (
        .i_state     (r_state),
        .i_operation (i_operation),
        .i_address   (i_address),
        .i_tx_byte   (i_tx_byte),
        .i_rx_bit    (i_rx_bit),
        .i_arb_line  (i_arb_line),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= ST_IDLE;
            r_state.cnt   <= '0;
            r_state.addr  <= '0;
            r_state.data  <= '0;
            r_state.rx    <= '0;
            r_state.arb   <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_drive_bit = r_result.drive_bit;
    assign o_out_bit   = r_result.out_bit;
    assign o_phase     = r_result.phase;
    assign o_rx_byte   = r_result.rx_byte;
    assign o_rx_done   = r_result.rx_done;
    assign o_lost_arb  = r_result.lost_arb;
    assign o_stop_hold = r_result.stop_hold;

endmodule

/* design/sfm_step.sv */
// sfm_step: next-state and result logic for one tick or start command
// depends on sfm_pkg

module sfm_step import sfm_pkg::*; (
    input  t_state               i_state,
    input  logic                 i_operation,
    input  logic [ADDR_BITS-1:0] i_address,
    input  logic [DATA_BITS-1:0] i_tx_byte,
    input  logic                 i_rx_bit,
    input  logic                 i_arb_line,
    output t_state               o_state,
    output t_result              o_result
);

    logic [START_LEN-1:0] pat_sh;
    logic [ADDR_BITS-1:0] addr_sh;
    logic [DATA_BITS-1:0] data_sh;
    logic [DATA_BITS-1:0] rx_mask;
    logic [DATA_BITS-1:0] rx_out;
    logic                 done;

    // current frame bit sits at the msb after shifting by the bit count
    assign pat_sh  = START_PATTERN << i_state.cnt;
    assign addr_sh = i_state.addr << i_state.cnt;
    assign data_sh = i_state.data << i_state.cnt;
    assign rx_mask = {1'b1, {(DATA_BITS-1){1'b0}}} >> i_state.cnt;

    // phase sequencing
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        done     = 1'b0;
        if (i_operation == OP_START) begin
            o_state.addr  = i_address;
            o_state.data  = i_tx_byte;
            o_state.rx    = '0;
            o_state.cnt   = '0;
            o_state.arb   = 1'b0;
            o_state.phase = ST_START;
        end else begin
            unique case (i_state.phase)
                ST_START: begin
                    if (i_state.cnt < CNT_W'(START_LEN)) begin
                        o_result.drive_bit = 1'b1;
                        o_result.out_bit   = pat_sh[START_LEN-1];
                        o_state.cnt        = i_state.cnt + 1'b1;
                    end else begin
                        o_state.cnt   = '0;
                        o_state.phase = ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    if (i_state.cnt < CNT_W'(ADDR_BITS)) begin
                        o_result.drive_bit = 1'b1;
                        o_result.out_bit   = addr_sh[ADDR_BITS-1];
                        // a driven one that reads back low means we lost the bus
                        if (addr_sh[ADDR_BITS-1] && !i_arb_line) begin
                            o_state.arb   = 1'b1;
                            o_state.phase = ST_LOST;
                        end
                        o_state.cnt = i_state.cnt + 1'b1;
                    end else begin
                        o_state.cnt   = '0;
                        o_state.phase = ST_DATA;
                    end
                end
                ST_DATA: begin
                    if (i_state.cnt < CNT_W'(DATA_BITS)) begin
                        o_result.drive_bit = 1'b1;
                        o_result.out_bit   = data_sh[DATA_BITS-1];
                        o_state.rx         = i_state.rx | (i_rx_bit ? rx_mask : '0);
                        o_state.cnt        = i_state.cnt + 1'b1;
                    end else begin
                        done          = 1'b1;
                        o_state.cnt   = '0;
                        o_state.phase = ST_STOP;
                    end
                end
                ST_STOP: begin
                    o_result.stop_hold = 1'b1;
                end
                ST_LOST: begin
                    o_state.phase = ST_IDLE;
                end
                default: begin
                end
            endcase
        end

        // received byte goes out, shifter clears when the byte completes
        rx_out = o_state.rx;
        if (done) begin
            o_state.rx = '0;
        end

        o_result.phase    = phase_code(o_state.phase);
        o_result.rx_byte  = rx_out;
        o_result.rx_done  = done;
        o_result.lost_arb = o_state.arb;
    end

endmodule

/* design/sfm_checker.sv */
// sfm_checker: port-level assertions for serial_frame_master, bound to the top level
// depends on sfm_pkg

module sfm_checker import sfm_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 i_operation,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic                 o_drive_bit,
    input logic                 o_out_bit,
    input logic [PHASE_W-1:0]   o_phase,
    input logic [DATA_BITS-1:0] o_rx_byte,
    input logic                 o_rx_done,
    input logic                 o_lost_arb,
    input logic                 o_stop_hold
);

    // a start transaction shows up next cycle as a clean start phase
    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_operation == OP_START) |=>
        (o_valid && o_phase == PH_CODE_START && !o_lost_arb && !o_drive_bit))
        else $error("start transaction did not produce a start phase result");

    // the byte completes on the transition into stop, with nothing driven
    a_done_enters_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rx_done) |-> (o_phase == PH_CODE_STOP && !o_drive_bit && !o_stop_hold))
        else $error("rx_done outside the transition into stop");

    // stop hold only while in stop, never with a frame bit driven
    a_hold_in_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stop_hold) |-> (o_phase == PH_CODE_STOP && !o_drive_bit))
        else $error("stop hold outside the stop phase");

    // an undriven tick carries a zero bit
    a_quiet_bit_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_drive_bit) |-> !o_out_bit)
        else $error("out_bit set on an undriven tick");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_phase) && $stable(o_rx_byte)))
        else $error("stalled result changed");

endmodule

bind serial_frame_master sfm_checker u_sfm_checker (.*);

/* sim/tb_serial_frame_master.sv */
// tb_serial_frame_master: self-checking bench for the serial frame master
// depends on sfm_pkg and serial_frame_master; a frame tracker predicts every result
// and random input gaps and receiver stalls exercise the valid/stall handshake

`timescale 1ns / 1ps

module tb_serial_frame_master;
    import sfm_pkg::*;

    localparam int unsigned ITEM_TARGET = 1250;
    localparam int unsigned CALM_FROM   = 1100;
    localparam int unsigned HOLD_AT     = 400;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned IDLE_LIMIT  = 3000;
    localparam int unsigned FRAME_TICKS = START_LEN + ADDR_BITS + DATA_BITS + 3;

    // tracks the frame state and holds the results still owed by the block
    class frame_tracker;
        logic [PHASE_W-1:0]   ph;
        int unsigned          cnt;
        logic [ADDR_BITS-1:0] addr_q;
        logic [DATA_BITS-1:0] data_q;
        logic [DATA_BITS-1:0] rx_q;
        logic                 arb_q;
        t_result              owed[$];
        int unsigned          mismatches;
        int unsigned          checked;
        int unsigned          bytes_received;
        int unsigned          arb_losses;

        function new();
            ph             = PH_CODE_IDLE;
            cnt            = 0;
            addr_q         = '0;
            data_q         = '0;
            rx_q           = '0;
            arb_q          = 1'b0;
            mismatches     = 0;
            checked        = 0;
            bytes_received = 0;
            arb_losses     = 0;
        endfunction

        // advance the frame by one accepted input transaction
        function void record_step(input logic op, input logic [ADDR_BITS-1:0] a,
                                  input logic [DATA_BITS-1:0] d, input logic rxb,
                                  input logic arb);
            t_result     r;
            int unsigned sh;
            r = '0;
            if (op == OP_START) begin
                addr_q = a;
                data_q = d;
                rx_q   = '0;
                cnt    = 0;
                arb_q  = 1'b0;
                ph     = PH_CODE_START;
            end else begin
                case (ph)
                    PH_CODE_START: begin
                        if (cnt < START_LEN) begin
                            r.drive_bit = 1'b1;
                            r.out_bit   = START_PATTERN[START_LEN - 1 - cnt];
                            cnt++;
                        end else begin
                            cnt = 0;
                            ph  = PH_CODE_ADDR;
                        end
                    end
                    PH_CODE_ADDR: begin
                        if (cnt < ADDR_BITS) begin
                            r.drive_bit = 1'b1;
                            r.out_bit   = addr_q[ADDR_BITS - 1 - cnt];
                            // only a driven one can lose arbitration
                            if (r.out_bit && !arb) begin
                                arb_q = 1'b1;
                                ph    = PH_CODE_LOST;
                                arb_losses++;
                            end
                            cnt++;
                        end else begin
                            cnt = 0;
                            ph  = PH_CODE_DATA;
                        end
                    end
                    PH_CODE_DATA: begin
                        if (cnt < DATA_BITS) begin
                            sh          = DATA_BITS - 1 - cnt;
                            r.drive_bit = 1'b1;
                            r.out_bit   = data_q[sh];
                            if (rxb)
                                rx_q[sh] = 1'b1;
                            cnt++;
                        end else begin
                            r.rx_done = 1'b1;
                            cnt       = 0;
                            ph        = PH_CODE_STOP;
                        end
                    end
                    PH_CODE_STOP: r.stop_hold = 1'b1;
                    PH_CODE_LOST: ph = PH_CODE_IDLE;
                    default: ;
                endcase
                r.rx_byte = rx_q;
                if (r.rx_done) begin
                    rx_q = '0;
                    bytes_received++;
                end
            end
            r.phase    = ph;
            r.lost_arb = arb_q;
            owed.push_back(r);
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // compare one accepted result with the oldest owed one
        function void check_result(input t_result got);
            t_result want;
            if (owed.size() == 0) begin
                $error("result transaction with nothing owed");
                mismatches++;
            end else begin
                want = owed.pop_front();
                checked++;
                compare_field("drive_bit", 32'(want.drive_bit), 32'(got.drive_bit));
                compare_field("out_bit", 32'(want.out_bit), 32'(got.out_bit));
                compare_field("phase", 32'(want.phase), 32'(got.phase));
                compare_field("rx_byte", 32'(want.rx_byte), 32'(got.rx_byte));
                compare_field("rx_done", 32'(want.rx_done), 32'(got.rx_done));
                compare_field("lost_arb", 32'(want.lost_arb), 32'(got.lost_arb));
                compare_field("stop_hold", 32'(want.stop_hold), 32'(got.stop_hold));
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic                 i_operation = OP_TICK;
    logic [ADDR_BITS-1:0] i_address   = '0;
    logic [DATA_BITS-1:0] i_tx_byte   = '0;
    logic                 i_rx_bit    = 1'b0;
    logic                 i_arb_line  = 1'b1;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic                 o_drive_bit;
    logic                 o_out_bit;
    logic [PHASE_W-1:0]   o_phase;
    logic [DATA_BITS-1:0] o_rx_byte;
    logic                 o_rx_done;
    logic                 o_lost_arb;
    logic                 o_stop_hold;

    frame_tracker tracker = new();
    int unsigned  items_offered = 0;
    int unsigned  inputs_taken  = 0;
    int unsigned  quiet_cycles  = 0;
    bit           calm          = 1'b0;
    bit           held_off      = 1'b0;

    serial_frame_master u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_address   (i_address),
        .i_tx_byte   (i_tx_byte),
        .i_rx_bit    (i_rx_bit),
        .i_arb_line  (i_arb_line),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_drive_bit (o_drive_bit),
        .o_out_bit   (o_out_bit),
        .o_phase     (o_phase),
        .o_rx_byte   (o_rx_byte),
        .o_rx_done   (o_rx_done),
        .o_lost_arb  (o_lost_arb),
        .o_stop_hold (o_stop_hold)
    );

    // 10 ns clock
    always #5 i_clk = ~i_clk;

    // monitor both channels
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            tracker.record_step(i_operation, i_address, i_tx_byte, i_rx_bit, i_arb_line);
            inputs_taken++;
        end
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_result({o_drive_bit, o_out_bit, o_phase, o_rx_byte,
                                  o_rx_done, o_lost_arb, o_stop_hold});
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    // receiver stalls, one long hold-off so the block backs up
    initial begin
        repeat (8) @(posedge i_clk);
        forever begin
            if (!held_off && inputs_taken >= HOLD_AT) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held_off = 1'b1;
            end else if (calm || $urandom_range(0, 3) != 0) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
        end
    end

    // offer one transaction and wait until it is taken
    task automatic send_item(input logic op, input logic [ADDR_BITS-1:0] a,
                             input logic [DATA_BITS-1:0] d, input logic rxb,
                             input logic arb);
        if (!calm && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_address   <= a;
        i_tx_byte   <= d;
        i_rx_bit    <= rxb;
        i_arb_line  <= arb;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        items_offered++;
    endtask

    task automatic send_tick(input logic rxb, input logic arb);
        send_item(OP_TICK, ADDR_BITS'($urandom_range(0, (1 << ADDR_BITS) - 1)),
                  DATA_BITS'($urandom_range(0, (1 << DATA_BITS) - 1)), rxb, arb);
    endtask

    task automatic send_start(input logic [ADDR_BITS-1:0] a, input logic [DATA_BITS-1:0] d);
        send_item(OP_START, a, d, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // start plus a run of ticks; arbitration is rarely pulled low
    task automatic send_frame(input int unsigned ticks);
        logic [ADDR_BITS-1:0] a;
        logic [DATA_BITS-1:0] d;
        case ($urandom_range(0, 7))
            0:       a = '0;
            1:       a = '1;
            default: a = ADDR_BITS'($urandom_range(0, (1 << ADDR_BITS) - 1));
        endcase
        case ($urandom_range(0, 7))
            0:       d = '0;
            1:       d = '1;
            default: d = DATA_BITS'($urandom_range(0, (1 << DATA_BITS) - 1));
        endcase
        send_start(a, d);
        repeat (ticks)
            send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 29) != 0);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle tick, start pattern, arbitration loss, abort
        send_tick(1'b1, 1'b0);
        send_start('1, '0);
        repeat (START_LEN + 1) send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_start('0, '1);
        repeat (START_LEN + 1) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_start(10'h2AA, 8'h55);
        repeat (3) send_tick(1'b1, 1'b1);

        // random: mostly whole frames, some aborted frames and noise
        while (items_offered < ITEM_TARGET) begin
            if (items_offered >= CALM_FROM)
                calm = 1'b1;
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 6))
                       send_item($urandom_range(0, 2) == 0 ? OP_START : OP_TICK,
                                 ADDR_BITS'($urandom_range(0, (1 << ADDR_BITS) - 1)),
                                 DATA_BITS'($urandom_range(0, (1 << DATA_BITS) - 1)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                1: send_frame($urandom_range(1, FRAME_TICKS - 1));
                default: send_frame(FRAME_TICKS + $urandom_range(0, 3));
            endcase
        end
        i_valid <= 1'b0;

        // drain, then let the block idle before the final check
        @(posedge i_clk);
        while (tracker.owed.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (tracker.owed.size() != 0) begin
            $error("%0d result transactions never arrived", tracker.owed.size());
            tracker.mismatches++;
        end
        $display("%0d input transactions, %0d results checked", inputs_taken, tracker.checked);
        $display("%0d bytes received in full frames, %0d arbitration losses",
                 tracker.bytes_received, tracker.arb_losses);
        if (tracker.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
design/sfm_pkg.sv
design/sfm_step.sv
design/serial_frame_master.sv
design/sfm_checker.sv
sim/tb_serial_frame_master.sv
